FILE: rtl/core/quadratic_root_solver_core_macros.svh
// Assertion macros for the quadratic root solver core
`ifndef QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH

// Check that a condition implies a consequence on the same edge
`define QRS_ASSERT_IMPL(lbl, clk_i, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that a condition implies a consequence on the next edge
`define QRS_ASSERT_NEXT(lbl, clk_i, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/qrs_pkg.sv
package qrs_pkg;
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_AZERO = 2'd1,
		ST_SAT  = 2'd2
	} status_t;
endpackage

FILE: rtl/core/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage
module qrs_sqrt #(
	parameter int IW = 64,
	parameter int OW = 32,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [IW-1:0] radicand,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [OW-1:0] root,
	output logic [SW-1:0] side_out
);
	localparam int XW = 2*OW;
	localparam int EW = OW + 3;

	logic [OW:0]          vld_s;
	logic [XW-1:0]        x_s  [OW+1];
	logic [EW-1:0]        e_s  [OW+1];
	logic [OW-1:0]        r_s  [OW+1];
	logic [SW-1:0]        sd_s [OW+1];

	assign vld_s[0] = in_valid;
	assign x_s[0]   = XW'(radicand);
	assign e_s[0]   = '0;
	assign r_s[0]   = '0;
	assign sd_s[0]  = side_in;

	for (genvar i = 0; i < OW; i++) begin : g_stage
		logic [EW-1:0] sh;
		logic [EW-1:0] trial;
		logic          ge;
		assign sh    = {e_s[i][EW-3:0], x_s[i][XW-1 -: 2]};
		assign trial = EW'({r_s[i], 2'b01});
		assign ge    = sh >= trial;
		// Bring in two radicand bits and keep the next root bit when 4r+1 fits
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]  <= x_s[i] << 2;
				e_s[i+1]  <= ge ? sh - trial : sh;
				r_s[i+1]  <= {r_s[i][OW-2:0], ge};
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	assign out_valid = vld_s[OW];
	assign root      = r_s[OW];
	assign side_out  = sd_s[OW];
endmodule

FILE: rtl/core/qrs_div.sv
// Pipelined restoring divider, one quotient bit per stage, truncating
module qrs_div #(
	parameter int NW = 80,
	parameter int DW = 50,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);
	logic [NW:0]   vld_s;
	logic [NW-1:0] n_s  [NW+1];
	logic [DW:0]   rm_s [NW+1];
	logic [DW-1:0] d_s  [NW+1];
	logic [SW-1:0] sd_s [NW+1];

	assign vld_s[0] = in_valid;
	assign n_s[0]   = num;
	assign rm_s[0]  = '0;
	assign d_s[0]   = den;
	assign sd_s[0]  = side_in;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW:0] sh;
		logic        ge;
		assign sh = {rm_s[i][DW-1:0], n_s[i][NW-1]};
		assign ge = sh >= {1'b0, d_s[i]};
		// Shift in one numerator bit and subtract where it fits
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rm_s[i+1] <= ge ? sh - {1'b0, d_s[i]} : sh;
				n_s[i+1]  <= {n_s[i][NW-2:0], ge};
				d_s[i+1]  <= d_s[i];
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	assign out_valid = vld_s[NW];
	assign quo       = n_s[NW];
	assign side_out  = sd_s[NW];
endmodule

FILE: rtl/core/quadratic_root_solver_core.sv
// Quadratic root solver: takes a, b, c (signed, FRAC_BITS fraction bits) per beat and returns
// both complex roots. Fully pipelined: one coefficient set per cycle while the output is not
// stalled. The pipeline is two input stages, WORD_BITS+2 square root stages, one numerator
// stage, WORD_BITS+FRAC_BITS+3 divider stages (the four bit-per-stage dividers run side by
// side) and the output register. A stall on the output freezes the whole pipeline. status:
// 0 ok, 1 a is zero, 2 saturated.
module quadratic_root_solver_core
	import qrs_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// coef_a, coef_b, coef_c from the lowest bit up
	input  logic [((3*WORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// first_real, first_imag, second_real, second_imag, status from the lowest bit up
	output logic [((4*WORD_BITS+2+7)/8)*8-1:0] m_tdata
);
	localparam int W   = WORD_BITS;
	localparam int DW  = 2*W + 3;       // |D| width
	localparam int RW  = W + 2;         // root width
	localparam int MW  = W + 3;         // numerator magnitude width
	localparam int NW  = MW + FRAC_BITS;
	localparam int QW  = W + 2;         // den width (2|a|)
	localparam int OBW = ((4*W+2+7)/8)*8;

	logic en;
	logic out_full_q;
	assign en       = !out_full_q || m_tready;
	assign s_tready = en;

	logic signed [W-1:0] a_in, b_in, c_in;
	assign a_in = s_tdata[W-1:0];
	assign b_in = s_tdata[2*W-1:W];
	assign c_in = s_tdata[3*W-1:2*W];

	// Unsigned magnitudes of the coefficients
	logic [W-1:0] mag_a, mag_b, mag_c;
	assign mag_a = a_in[W-1] ? -a_in : a_in;
	assign mag_b = b_in[W-1] ? -b_in : b_in;
	assign mag_c = c_in[W-1] ? -c_in : c_in;

	// Stage 1: magnitudes and products
	logic            v_s1;
	logic [2*W-1:0]  bb_s1, ac_s1;
	logic signed [W-1:0] a_s1, b_s1;
	logic            opp_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1  <= (2*W)'(mag_b) * (2*W)'(mag_b);
			ac_s1  <= (2*W)'(mag_a) * (2*W)'(mag_c);
			opp_s1 <= (c_in != '0) && (a_in[W-1] != c_in[W-1]);
			a_s1   <= a_in;
			b_s1   <= b_in;
		end
	end

	// Stage 2: discriminant magnitude and sign
	logic            v_s2, dneg_s2;
	logic [DW-1:0]   d_s2;
	logic signed [W-1:0] a_s2, b_s2;
	logic [DW-1:0]   bbx, acx;
	assign bbx = DW'(bb_s1);
	assign acx = DW'(ac_s1) << 2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (opp_s1) begin
				d_s2 <= bbx + acx; dneg_s2 <= 1'b0;
			end else if (bbx >= acx) begin
				d_s2 <= bbx - acx; dneg_s2 <= 1'b0;
			end else begin
				d_s2 <= acx - bbx; dneg_s2 <= 1'b1;
			end
			a_s2 <= a_s1;
			b_s2 <= b_s1;
		end
	end

	// Square root with a, b, sign carried alongside
	localparam int SDW = 2*W + 1;
	logic           sq_v;
	logic [RW-1:0]  sq_r;
	logic [SDW-1:0] sq_sd;
	qrs_sqrt #(.IW(DW), .OW(RW), .SW(SDW)) u_sqrt (
		.clk, .arst_n, .en, .in_valid(v_s2), .radicand(d_s2),
		.side_in({dneg_s2, b_s2, a_s2}), .out_valid(sq_v), .root(sq_r), .side_out(sq_sd)
	);

	// Stage 3: numerators as sign and magnitude
	logic signed [W-1:0] a3, b3;
	logic                dneg3;
	assign a3 = sq_sd[W-1:0];
	assign b3 = sq_sd[2*W-1:W];
	assign dneg3 = sq_sd[2*W];
	logic signed [MW:0] nb, ns, n0, n1, n2, n3;
	assign nb = -(MW+1)'(b3);
	assign ns = (MW+1)'(sq_r);
	assign n0 = dneg3 ? nb : nb + ns;
	assign n1 = dneg3 ? ns : '0;
	assign n2 = dneg3 ? nb : nb - ns;
	assign n3 = dneg3 ? -ns : '0;

	logic            v_s3, az_s3;
	logic [3:0]      ng_s3;
	logic [NW-1:0]   m_s3 [4];
	logic [QW-1:0]   den_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= sq_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_s3[0] <= NW'(MW'(n0[MW] ? -n0 : n0)) << FRAC_BITS;
			m_s3[1] <= NW'(MW'(n1[MW] ? -n1 : n1)) << FRAC_BITS;
			m_s3[2] <= NW'(MW'(n2[MW] ? -n2 : n2)) << FRAC_BITS;
			m_s3[3] <= NW'(MW'(n3[MW] ? -n3 : n3)) << FRAC_BITS;
			ng_s3   <= {n3[MW], n2[MW], n1[MW], n0[MW]} ^ {4{a3[W-1]}};
			den_s3  <= QW'(a3[W-1] ? -(QW)'(a3) : (QW)'(a3)) << 1;
			az_s3   <= (a3 == '0);
		end
	end

	// Four parallel dividers
	logic [3:0]    dv_v;
	logic [NW-1:0] q [4];
	logic [4:0]    side [4];
	for (genvar k = 0; k < 4; k++) begin : g_div
		qrs_div #(.NW(NW), .DW(QW), .SW(5)) u_div (
			.clk, .arst_n, .en, .in_valid(v_s3), .num(m_s3[k]),
			.den(az_s3 ? QW'(1) : den_s3), .side_in({az_s3, ng_s3}),
			.out_valid(dv_v[k]), .quo(q[k]), .side_out(side[k])
		);
	end

	// Saturate, sign, pack into the output register
	logic [4*W-1:0] parts;
	logic [3:0]     satv;
	for (genvar k = 0; k < 4; k++) begin : g_sat
		logic [NW-1:0] lim;
		logic          ov;
		logic [W-1:0]  mag;
		assign lim = side[0][k] ? (NW'(1) << (W-1)) : (NW'(1) << (W-1)) - 1'b1;
		assign ov  = q[k] > lim;
		assign mag = ov ? W'(lim) : W'(q[k]);
		assign satv[k] = ov;
		assign parts[k*W +: W] = side[0][4] ? '0 : (side[0][k] ? -mag : mag);
	end

	status_t st;
	assign st = side[0][4] ? ST_AZERO : ((|satv) ? ST_SAT : ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_full_q <= 1'b0;
		else if (en) out_full_q <= dv_v[0];
	end
	always_ff @(posedge clk) begin
		if (en) m_tdata <= OBW'({st, parts});
	end
	assign m_tvalid = out_full_q;

`include "quadratic_root_solver_core_macros.svh"
	`QRS_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !out_full_q, s_tready)
	`QRS_ASSERT_IMPL(a_div_lockstep, clk, arst_n, 1'b1, dv_v == {4{dv_v[0]}})
	`QRS_ASSERT_NEXT(a_hold_on_stall, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
endmodule

FILE: bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import qrs_pkg::*;

	localparam int FB = 16;
	localparam int WB = 32;
	localparam int IN_W = ((3*WB+7)/8)*8;
	localparam int OUT_W = ((4*WB+2+7)/8)*8;
	localparam int LATENCY = 2*WB + FB + 9;
	localparam int STALL_LIMIT = 20*LATENCY + 2000;
	localparam int N_RANDOM = 400;

	typedef struct packed {
		logic [1:0]    status;
		logic [WB-1:0] im2;
		logic [WB-1:0] re2;
		logic [WB-1:0] im1;
		logic [WB-1:0] re1;
	} roots_t;

	// Root predictor and store of pending root sets
	class roots_board;
		roots_t pending[$];
		int errors;

		// trunc(num * 2^FB / den), saturated to the word
		function automatic logic signed [WB-1:0] divide_part(logic signed [WB+1:0] num,
				logic [WB:0] den, bit a_neg, ref bit sat);
			logic [127:0] mag;
			logic [127:0] q;
			logic [127:0] lim;
			bit neg;
			neg = (num < 0) != a_neg;
			mag = num < 0 ? 128'(-num) : 128'(num);
			q = (mag << FB) / den;
			lim = neg ? (128'd1 << (WB-1)) : (128'd1 << (WB-1)) - 1;
			if (q > lim) begin
				q = lim;
				sat = 1;
			end
			return neg ? WB'(-q) : WB'(q);
		endfunction

		function automatic logic [63:0] isqrt(logic [127:0] x);
			logic [63:0] r;
			logic [63:0] t;
			r = 0;
			for (int i = 63; i >= 0; i--) begin
				t = r | (64'd1 << i);
				if (128'(t) * 128'(t) <= x)
					r = t;
			end
			return r;
		endfunction

		function void note_coefs(logic signed [WB-1:0] a, logic signed [WB-1:0] b,
				logic signed [WB-1:0] c);
			roots_t r;
			logic signed [127:0] d;
			logic [63:0] s;
			logic [WB:0] den;
			bit sat;
			r = '0;
			sat = 0;
			if (a == 0) begin
				r.status = ST_AZERO;
			end else begin
				d = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
				s = isqrt(d < 0 ? 128'(-d) : 128'(d));
				den = (WB+1)'(a < 0 ? -65'(a) : 65'(a)) << 1;
				if (d >= 0) begin
					r.re1 = divide_part(-(WB+2)'(b) + (WB+2)'(s), den, a < 0, sat);
					r.re2 = divide_part(-(WB+2)'(b) - (WB+2)'(s), den, a < 0, sat);
				end else begin
					r.re1 = divide_part(-(WB+2)'(b), den, a < 0, sat);
					r.re2 = r.re1;
					r.im1 = divide_part((WB+2)'(s), den, a < 0, sat);
					r.im2 = divide_part(-(WB+2)'(s), den, a < 0, sat);
				end
				r.status = sat ? ST_SAT : ST_OK;
			end
			pending.push_back(r);
		endfunction

		function void check_roots(roots_t got);
			roots_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.re1 !== e.re1) begin
				$display("%0t: first_real exp %h got %h", $time, e.re1, got.re1);
				errors++;
			end
			if (got.im1 !== e.im1) begin
				$display("%0t: first_imag exp %h got %h", $time, e.im1, got.im1);
				errors++;
			end
			if (got.re2 !== e.re2) begin
				$display("%0t: second_real exp %h got %h", $time, e.re2, got.re2);
				errors++;
			end
			if (got.im2 !== e.im2) begin
				$display("%0t: second_imag exp %h got %h", $time, e.im2, got.im2);
				errors++;
			end
			if (got.status !== e.status) begin
				$display("%0t: status exp %0d got %0d", $time, e.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_W-1:0] m_tdata;

	roots_board board = new();
	bit calm = 0;
	int idle_cycles = 0;

	quadratic_root_solver_core #(.FRAC_BITS(FB), .WORD_BITS(WB)) uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Check result beats; the block below drives backpressure
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			board.check_roots(roots_t'(m_tdata[4*WB+1:0]));
	end

	always @(negedge clk)
		m_tready <= calm || ($urandom_range(99) >= 29);

	// Watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [WB-1:0] rand_coef();
		case ($urandom_range(5))
			0: return WB'($urandom_range(7)) - 3;
			1: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
			2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Offer one coefficient set, with a random gap first
	task automatic send_coefs(logic [WB-1:0] a, logic [WB-1:0] b, logic [WB-1:0] c);
		while (!calm && $urandom_range(99) < 29) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tdata <= IN_W'({c, b, a});
		s_tvalid <= 1;
		do
			@(posedge clk);
		while (!s_tready);
		board.note_coefs(a, b, c);
		@(negedge clk);
	endtask

	localparam logic [WB-1:0] ONE = 32'h0001_0000;
	localparam logic [WB-1:0] MAXV = 32'h7fff_ffff;
	localparam logic [WB-1:0] MINV = 32'h8000_0000;

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// Directed: a zero, real, complex, double root, saturation, extremes
		send_coefs(0, ONE, ONE);
		send_coefs(0, 0, 0);
		send_coefs(ONE, 0, -ONE);
		send_coefs(ONE, 0, ONE);
		send_coefs(ONE, -2*ONE, ONE);
		send_coefs(-ONE, 3*ONE, 2*ONE);
		send_coefs(1, MAXV, 0);
		send_coefs(1, 0, MAXV);
		send_coefs(-1, MINV, MINV);
		send_coefs(MAXV, MAXV, MAXV);
		send_coefs(MINV, MINV, MINV);
		send_coefs(MINV, MAXV, MAXV);
		send_coefs(MAXV, MINV, MINV);
		send_coefs(-1, -1, -1);
		send_coefs(1, 1, 1);
		send_coefs(ONE, 0, 0);
		send_coefs(-ONE, 32'hffff_ffff, 32'h5555_aaaa);
		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= 150 && i < 230);
			send_coefs(rand_coef(), rand_coef(), rand_coef());
		end
		s_tvalid <= 0;
		calm = 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/qrs_pkg.sv
rtl/core/qrs_sqrt.sv
rtl/core/qrs_div.sv
rtl/core/quadratic_root_solver_core.sv
bench/testbench.sv
